@@ hdl/emp_pkg.sv @@
`timescale 1ns / 1ps

package emp_pkg;

    localparam int TIME_BITS    = 24;
    localparam int FRAC_BITS    = 15;
    localparam int CURVE_ENTRIES = 256;
    localparam int IDX_BITS     = $clog2(CURVE_ENTRIES);
    localparam int CNT_BITS     = 5;

    // easing codes
    localparam logic [2:0] EASE_CONST   = 3'd0;
    localparam logic [2:0] EASE_LINEAR  = 3'd1;
    localparam logic [2:0] EASE_SINE    = 3'd2;
    localparam logic [2:0] EASE_SIGMOID = 3'd3;
    localparam logic [2:0] EASE_BEZIER  = 3'd4;

    // register indexes
    localparam logic [2:0] REG_START_X = 3'd0;
    localparam logic [2:0] REG_START_Y = 3'd1;
    localparam logic [2:0] REG_END_X   = 3'd2;
    localparam logic [2:0] REG_END_Y   = 3'd3;
    localparam logic [2:0] REG_PERIOD  = 3'd4;
    localparam logic [2:0] REG_YOYO    = 3'd5;
    localparam logic [2:0] REG_MODE    = 3'd6;

    // ceil(2^23 / 10), exact floor divide by ten for values below 2^22
    localparam logic [19:0] RECIP_TEN = 20'd838861;

    typedef logic [15:0] t_curve [0:CURVE_ENTRIES];

    typedef struct packed {
        logic accept;
        logic div_step;
        logic t_start;
        logic axis_y;
        logic ld_x;
        logic ld_y;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_stat;

    // shift and subtract long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sample table built at elaboration from q2.30 power series
    function automatic t_curve build_curve(input logic sigmoid);
        t_curve      tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] dvsr;
        logic [63:0] val;
        for (int k = 0; k <= CURVE_ENTRIES; k++) begin
            x = (64'(k) << 30) >> IDX_BITS;
            if (sigmoid) begin
                term = 64'd1 << 30;
                sum  = 64'd1 << 30;
                for (int n = 1; n <= 16; n++) begin
                    term = udiv64((term * x) >> 30, 64'(n));
                    if ((n & 1) == 1) sum = sum - term;
                    else sum = sum + term;
                end
                dvsr = (64'd1 << 30) + sum;
                val  = udiv64((64'd1 << 30) << FRAC_BITS, dvsr);
            end else begin
                x2   = (x * x) >> 30;
                term = x;
                sum  = x;
                for (int n = 1; n <= 7; n++) begin
                    term = udiv64((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
                    if ((n & 1) == 1) sum = sum - term;
                    else sum = sum + term;
                end
                val = sum >> (30 - FRAC_BITS);
            end
            tab[k] = val[15:0];
        end
        return tab;
    endfunction

    localparam t_curve SIN_TAB = build_curve(1'b0);
    localparam t_curve SIG_TAB = build_curve(1'b1);

endpackage

@@ hdl/emp_ctrl.sv @@
`timescale 1ns / 1ps

module emp_ctrl import emp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MOD    = 4'd1;
    localparam logic [3:0] S_TSTART = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_FOLD   = 4'd4;
    localparam logic [3:0] S_E1     = 4'd5;
    localparam logic [3:0] S_E2     = 4'd6;
    localparam logic [3:0] S_E3     = 4'd7;
    localparam logic [3:0] S_E4     = 4'd8;
    localparam logic [3:0] S_MULX   = 4'd9;
    localparam logic [3:0] S_ADDX   = 4'd10;
    localparam logic [3:0] S_ADDY   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_TSTART;
            end
            S_TSTART: begin
                o_cmd.t_start = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_FOLD;
            end
            S_FOLD: n_state = S_E1;
            S_E1:   n_state = S_E2;
            S_E2:   n_state = S_E3;
            S_E3:   n_state = S_E4;
            S_E4:   n_state = S_MULX;
            S_MULX: n_state = S_ADDX;
            S_ADDX: begin
                o_cmd.ld_x   = 1'b1;
                o_cmd.axis_y = 1'b1;
                n_state      = S_ADDY;
            end
            S_ADDY: begin
                o_cmd.ld_y = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

@@ hdl/emp_datapath.sv @@
`timescale 1ns / 1ps

module emp_datapath import emp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [TIME_BITS-1:0]  i_delta_ticks,
    input  logic signed [31:0]    i_current_x,
    input  logic signed [31:0]    i_current_y,
    input  logic signed [31:0]    i_start_x,
    input  logic signed [31:0]    i_start_y,
    input  logic signed [31:0]    i_end_x,
    input  logic signed [31:0]    i_end_y,
    input  logic [TIME_BITS-1:0]  i_period,
    input  logic                  i_yoyo,
    input  logic [2:0]            i_mode,
    output logic signed [31:0]    o_velocity_x,
    output logic signed [31:0]    o_velocity_y
);

    localparam logic [16:0] T_ONE = 17'(1) << FRAC_BITS;

    // shared restoring divider
    logic [TIME_BITS-1:0] r_per;
    logic [TIME_BITS-1:0] r_rem;
    logic [TIME_BITS:0]   r_quo;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [TIME_BITS-1:0] r_phase;
    logic [TIME_BITS:0]   w_cand;
    logic                 w_qbit;

    logic signed [31:0] r_cur_x, r_cur_y;

    assign w_cand        = {r_rem, r_quo[TIME_BITS]};
    assign w_qbit        = (w_cand >= {1'b0, r_per});
    assign o_stat.div_last = (r_cnt == CNT_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_phase <= '0;
        end else if (i_cmd.accept) begin
            r_cnt <= CNT_BITS'(TIME_BITS + 1);
        end else if (i_cmd.t_start) begin
            r_cnt   <= CNT_BITS'(FRAC_BITS);
            r_phase <= r_rem;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_per   <= (i_period == '0) ? TIME_BITS'(1) : i_period;
            r_rem   <= '0;
            r_quo   <= {1'b0, r_phase} + {1'b0, i_delta_ticks};
            r_cur_x <= i_current_x;
            r_cur_y <= i_current_y;
        end else if (i_cmd.t_start) begin
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? TIME_BITS'(w_cand - {1'b0, r_per}) : w_cand[TIME_BITS-1:0];
            r_quo <= {r_quo[TIME_BITS-1:0], w_qbit};
        end
    end

    // fold and easing chain, settles while the controller waits
    logic [16:0] w_tdbl;
    logic [15:0] w_t;
    logic [15:0] r_t;
    logic [31:0] r_m1;
    logic [15:0] r_a, r_b;
    logic [FRAC_BITS-1:0] r_f;
    logic [15:0] r_t2;
    logic [31:0] r_m2;
    logic [31:0] r_lin;
    logic        r_dn;
    logic [15:0] r_a2;
    logic [20:0] r_poly;
    logic [15:0] r_v;
    logic [IDX_BITS:0]   w_idx;
    logic [IDX_BITS:0]   w_idx1;
    logic [15:0] w_a, w_b;
    logic [40:0] w_bez;
    logic [15:0] w_v;

    always_comb begin
        w_tdbl = i_yoyo ? {1'b0, r_quo[FRAC_BITS-1:0], 1'b0}
                        : {2'b0, r_quo[FRAC_BITS-1:0]};
        if (w_tdbl > T_ONE) w_tdbl = (T_ONE << 1) - w_tdbl;
        w_t = w_tdbl[15:0];
    end

    assign w_idx  = r_t[FRAC_BITS:FRAC_BITS-IDX_BITS];
    assign w_idx1 = w_idx[IDX_BITS] ? w_idx : w_idx + 1'b1;

    always_comb begin
        if (i_mode == EASE_SINE) begin
            w_a = SIN_TAB[w_idx];
            w_b = SIN_TAB[w_idx1];
        end else begin
            w_a = SIG_TAB[w_idx];
            w_b = SIG_TAB[w_idx1];
        end
    end

    assign w_bez = 41'(r_poly[19:0]) * 41'(RECIP_TEN);

    always_comb begin
        case (i_mode) inside
            EASE_LINEAR: w_v = r_t;
            EASE_SINE, EASE_SIGMOID: begin
                w_v = r_dn ? r_a2 - 16'(r_lin >> FRAC_BITS) : r_a2 + 16'(r_lin >> FRAC_BITS);
            end
            EASE_BEZIER: w_v = w_bez[38:23];
            default:     w_v = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_t    <= w_t;
        r_m1   <= 32'(r_t) * 32'(r_t);
        r_a    <= w_a;
        r_b    <= w_idx[IDX_BITS] ? w_a : w_b;
        r_f    <= FRAC_BITS'({r_t[FRAC_BITS-IDX_BITS-1:0], {IDX_BITS{1'b0}}});
        r_t2   <= 16'(r_m1 >> FRAC_BITS);
        r_m2   <= 32'(16'(r_m1 >> FRAC_BITS)) * 32'(r_t);
        r_lin  <= 32'((r_b >= r_a) ? r_b - r_a : r_a - r_b) * 32'(r_f);
        r_dn   <= (r_b < r_a);
        r_a2   <= r_a;
        r_poly <= 21'(12) * 21'(r_t) - 21'(6) * 21'(r_t2)
                  + 21'(4) * 21'(r_m2 >> FRAC_BITS);
        r_v    <= w_v;
    end

    // interpolation, one multiplier shared by both axes
    logic signed [32:0] w_diff;
    logic signed [49:0] r_prod;
    logic signed [31:0] w_s, w_cur;
    logic signed [36:0] w_d;
    logic signed [31:0] w_sat;
    logic signed [31:0] r_vx, r_vy;
    logic signed [31:0] r_ox, r_oy;

    assign w_diff = i_cmd.axis_y ? 33'(i_end_y) - 33'(i_start_y)
                                 : 33'(i_end_x) - 33'(i_start_x);
    assign w_s    = i_cmd.ld_y ? i_start_y : i_start_x;
    assign w_cur  = i_cmd.ld_y ? r_cur_y : r_cur_x;
    assign w_d    = 37'(w_s) + 37'(r_prod >>> FRAC_BITS) - 37'(w_cur);

    always_comb begin
        if (w_d > 37'sd2147483647) w_sat = 32'sh7FFFFFFF;
        else if (w_d < -37'sd2147483648) w_sat = 32'sh80000000;
        else w_sat = w_d[31:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 50'(w_diff) * 50'(signed'({1'b0, r_v}));
        if (i_cmd.ld_x) r_vx <= w_sat;
        if (i_cmd.ld_y) r_vy <= w_sat;
        if (i_cmd.out_load) begin
            r_ox <= r_vx;
            r_oy <= r_vy;
        end
    end

    assign o_velocity_x = r_ox;
    assign o_velocity_y = r_oy;

endmodule

@@ hdl/eased_motion_profile_generator.sv @@
`timescale 1ns / 1ps
// each input runs phase modulo, normalizing divide, easing and lerp in turn
// before a new one is taken; both divides use the shared restoring divider
//   (25 steps for the phase modulo, 15 steps for the normalizing divide)
// the next input is taken while a finished result waits in the output register
// reset (synchronous, active low) clears phase, control state and config registers

module eased_motion_profile_generator import emp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [TIME_BITS-1:0]  i_delta_ticks,
    input  logic signed [31:0]    i_current_x,
    input  logic signed [31:0]    i_current_y,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_velocity_x,
    output logic signed [31:0]    o_velocity_y
);

    // configuration registers
    logic signed [31:0]   r_start_x, r_start_y, r_end_x, r_end_y;
    logic [TIME_BITS-1:0] r_period;
    logic                 r_yoyo;
    logic [2:0]           r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
            r_period  <= TIME_BITS'(1);
            r_yoyo    <= 1'b0;
            r_mode    <= EASE_CONST;
        end else if (i_cfg_we) begin
            // writes beyond the register list are dropped
            unique case (i_cfg_idx)
                REG_START_X: r_start_x <= i_cfg_wdata;
                REG_START_Y: r_start_y <= i_cfg_wdata;
                REG_END_X:   r_end_x   <= i_cfg_wdata;
                REG_END_Y:   r_end_y   <= i_cfg_wdata;
                REG_PERIOD:  r_period  <= i_cfg_wdata[TIME_BITS-1:0];
                REG_YOYO:    r_yoyo    <= i_cfg_wdata[0];
                REG_MODE:    r_mode    <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: accept, divide, ease, interpolate, hand off
    emp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // phase, divider, easing curves, lerp and saturation
    emp_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_delta_ticks (i_delta_ticks),
        .i_current_x   (i_current_x),
        .i_current_y   (i_current_y),
        .i_start_x     (r_start_x),
        .i_start_y     (r_start_y),
        .i_end_x       (r_end_x),
        .i_end_y       (r_end_y),
        .i_period      (r_period),
        .i_yoyo        (r_yoyo),
        .i_mode        (r_mode),
        .o_velocity_x  (o_velocity_x),
        .o_velocity_y  (o_velocity_y)
    );

endmodule
